@@ sv/mpwm_pkg.sv @@
// Package for the calibrated motor power to PWM unit.
// Holds the calibration tables, field widths and drive codes.
// No dependencies.
package mpwm_pkg;

	localparam int NUM_MOTORS = 4;
	localparam int CAL_POINTS = 4;

	localparam int MOTOR_W = 2;
	localparam int DIR_W   = 2;
	localparam int POWER_W = 7;
	localparam int RPM_W   = 15;
	localparam int PWM_W   = 8;
	localparam int DP_W    = 7;
	localparam int PROD_W  = 22;
	localparam int Q_W     = 7;

	localparam logic [POWER_W-1:0] POWER_MAX    = 7'd100;
	localparam logic [7:0]         TARGET_SCALE = 8'd237;

	localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
	localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

	localparam logic [PWM_W-1:0] PWM_BELOW = 8'd64;
	localparam logic [PWM_W-1:0] PWM_ABOVE = 8'd255;
	localparam logic [PWM_W-1:0] PWM_OFF   = 8'd0;

	typedef logic [RPM_W-1:0] rpm_t;
	typedef logic [PWM_W-1:0] pwm_t;

	localparam rpm_t RPM_TAB [4][4] = '{
		'{15'd8100, 15'd18900, 15'd22800, 15'd25800},
		'{15'd6900, 15'd16404, 15'd20400, 15'd23700},
		'{15'd7200, 15'd18000, 15'd22500, 15'd23700},
		'{15'd7500, 15'd18000, 15'd24000, 15'd27300}
	};

	localparam pwm_t PWM_PTS [4] = '{8'd64, 8'd128, 8'd192, 8'd255};

	typedef enum logic [1:0] {
		SEG_INTERP,
		SEG_BELOW,
		SEG_ABOVE
	} seg_mode_t;

	typedef struct packed {
		logic [MOTOR_W-1:0] motor;
		logic               in1;
		logic               in2;
		logic               stop;
		seg_mode_t          mode;
		pwm_t               plo;
	} ctl_t;

endpackage

@@ sv/motor_power_to_pwm_calibrated_unit.sv @@
// Top level of the calibrated motor power to PWM unit.
// Five-stage pipeline: target, segment search, product, two divider halves.
// Depends on mpwm_pkg.
//
//   channel  | handshake             | fields
//   ---------+-----------------------+--------------------------------------------
//   command  | cmd_valid / cmd_stall | motor_id, direction, power
//   result   | res_valid / res_stall | motor_out, bridge_in1, bridge_in2, pwm_duty
//
// One transaction per cycle sustained while res_stall is low; from the accepting edge a
// command passes the segment search, product and two divider registers, the seven-step
// restoring divider split over two stages, to res_valid. Reset clears the stage valid bits only.
// Each stage fills whenever it is empty or the next stage advances, so bubbles
// close up under a result stall and nothing is dropped or repeated.
module motor_power_to_pwm_calibrated_unit
	import mpwm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [MOTOR_W-1:0] motor_id,
	input  logic [DIR_W-1:0]   direction,
	input  logic [POWER_W-1:0] power,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [MOTOR_W-1:0] motor_out,
	output logic               bridge_in1,
	output logic               bridge_in2,
	output logic [PWM_W-1:0]   pwm_duty
);

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [MOTOR_W-1:0] motor_s1;
	logic [DIR_W-1:0]   dir_s1;
	logic [MOTOR_W-1:0] sel_s1;
	rpm_t               target_s1;

	ctl_t               ctl_s2, ctl_s3, ctl_s4;
	rpm_t               diff_s2, dr_s2, dr_s3, dr_s4;
	logic [DP_W-1:0]    dp_s2;
	logic [PROD_W-1:0]  prod_s3, rem_s4;
	logic [Q_W-1:0]     q_s4;
	logic [MOTOR_W-1:0] motor_s5;
	logic               in1_s5;
	logic               in2_s5;
	pwm_t               pwm_s5;

	logic adv1, adv2, adv3, adv4, adv5;

	logic [POWER_W-1:0] psat;
	logic [MOTOR_W-1:0] sel_in;
	rpm_t               target_in;

	ctl_t               ctl2_d;
	rpm_t               diff_d, dr_d;
	logic [DP_W-1:0]    dp_d;
	logic [PROD_W-1:0]  rem4_d, rem5_d;
	logic [Q_W-1:0]     q4_d, q5_d;
	pwm_t               pwm_d;

	assign adv5 = !v_s5 || !res_stall;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign cmd_stall = !adv1;

	// saturate power, scale to target speed, clamp motor select
	always_comb begin
		psat = (power > POWER_MAX) ? POWER_MAX : power;
		target_in = RPM_W'(psat) * RPM_W'(TARGET_SCALE);
		sel_in = (int'(motor_id) >= NUM_MOTORS) ? MOTOR_W'(NUM_MOTORS - 1) : motor_id;
	end

	// segment search on the selected calibration curve
	always_comb begin
		logic hit;
		hit = 1'b0;
		ctl2_d = '0;
		ctl2_d.motor = motor_s1;
		ctl2_d.in1 = (dir_s1 == DIR_FWD);
		ctl2_d.in2 = (dir_s1 == DIR_REV);
		ctl2_d.stop = (dir_s1 != DIR_FWD) && (dir_s1 != DIR_REV);
		diff_d = '0;
		dr_d = RPM_W'(1);
		dp_d = '0;
		for (int i = 0; i < CAL_POINTS - 1; i++) begin
			if (!hit && target_s1 >= RPM_TAB[sel_s1][i] &&
			    target_s1 <= RPM_TAB[sel_s1][i+1]) begin
				hit = 1'b1;
				ctl2_d.plo = PWM_PTS[i];
				diff_d = target_s1 - RPM_TAB[sel_s1][i];
				if (RPM_TAB[sel_s1][i+1] != RPM_TAB[sel_s1][i]) begin
					dr_d = RPM_TAB[sel_s1][i+1] - RPM_TAB[sel_s1][i];
					dp_d = DP_W'(PWM_PTS[i+1] - PWM_PTS[i]);
				end
			end
		end
		if (target_s1 < RPM_TAB[sel_s1][0])
			ctl2_d.mode = SEG_BELOW;
		else if (hit)
			ctl2_d.mode = SEG_INTERP;
		else
			ctl2_d.mode = SEG_ABOVE;
	end

	// restoring divide, quotient bits 6..4
	always_comb begin
		logic [PROD_W-1:0] dsh;
		rem4_d = prod_s3;
		q4_d = '0;
		for (int j = Q_W - 1; j >= 4; j--) begin
			dsh = PROD_W'(dr_s3) << j;
			if (rem4_d >= dsh) begin
				rem4_d = rem4_d - dsh;
				q4_d[j] = 1'b1;
			end
		end
	end

	// restoring divide, quotient bits 3..0, then select the duty
	always_comb begin
		logic [PROD_W-1:0] dsh;
		rem5_d = rem_s4;
		q5_d = q_s4;
		for (int j = 3; j >= 0; j--) begin
			dsh = PROD_W'(dr_s4) << j;
			if (rem5_d >= dsh) begin
				rem5_d = rem5_d - dsh;
				q5_d[j] = 1'b1;
			end
		end
		if (ctl_s4.stop)
			pwm_d = PWM_OFF;
		else begin
			case (ctl_s4.mode)
				SEG_BELOW: pwm_d = PWM_BELOW;
				SEG_ABOVE: pwm_d = PWM_ABOVE;
				SEG_INTERP: pwm_d = ctl_s4.plo + PWM_W'(q5_d);
				default: pwm_d = PWM_ABOVE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= cmd_valid;
			if (adv2)
				v_s2 <= v_s1;
			if (adv3)
				v_s3 <= v_s2;
			if (adv4)
				v_s4 <= v_s3;
			if (adv5)
				v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			motor_s1 <= motor_id;
			dir_s1 <= direction;
			sel_s1 <= sel_in;
			target_s1 <= target_in;
		end
		if (adv2) begin
			ctl_s2 <= ctl2_d;
			diff_s2 <= diff_d;
			dr_s2 <= dr_d;
			dp_s2 <= dp_d;
		end
		if (adv3) begin
			ctl_s3 <= ctl_s2;
			prod_s3 <= PROD_W'(diff_s2) * PROD_W'(dp_s2);
			dr_s3 <= dr_s2;
		end
		if (adv4) begin
			ctl_s4 <= ctl_s3;
			rem_s4 <= rem4_d;
			q_s4 <= q4_d;
			dr_s4 <= dr_s3;
		end
		if (adv5) begin
			motor_s5 <= ctl_s4.motor;
			in1_s5 <= ctl_s4.in1;
			in2_s5 <= ctl_s4.in2;
			pwm_s5 <= pwm_d;
		end
	end

	assign res_valid = v_s5;
	assign motor_out = motor_s5;
	assign bridge_in1 = in1_s5;
	assign bridge_in2 = in2_s5;
	assign pwm_duty = pwm_s5;

endmodule

@@ sv/mpwm_checker.sv @@
// Port-level checker for the calibrated motor power to PWM unit.
// Bound to motor_power_to_pwm_calibrated_unit; depends on mpwm_pkg.
module mpwm_checker
	import mpwm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input logic [MOTOR_W-1:0] motor_out,
	input logic               bridge_in1,
	input logic               bridge_in2,
	input logic [PWM_W-1:0]   pwm_duty
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(pwm_duty) && $stable(motor_out))
		else $error("stalled result transaction changed");

	a_no_shoot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(bridge_in1 && bridge_in2))
		else $error("both bridge inputs high");

	a_stop_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !bridge_in1 && !bridge_in2 |-> pwm_duty == PWM_OFF)
		else $error("stopped motor with nonzero duty");

	a_drive_min: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (bridge_in1 || bridge_in2) |-> pwm_duty >= PWM_BELOW)
		else $error("driven motor below lowest calibration duty");

endmodule

bind motor_power_to_pwm_calibrated_unit mpwm_checker u_mpwm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.motor_out(motor_out),
	.bridge_in1(bridge_in1),
	.bridge_in2(bridge_in2),
	.pwm_duty(pwm_duty)
);

@@ sim/tb_motor_power_to_pwm_calibrated_unit.sv @@
// Testbench for motor_power_to_pwm_calibrated_unit: directed corner commands, random streams,
// long result back-pressure and drain pauses, all checked against a local calibration model.
// Depends on mpwm_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb_motor_power_to_pwm_calibrated_unit;
	import mpwm_pkg::*;

	localparam logic [DIR_W-1:0] DIR_STOP_LO = 2'd0;
	localparam logic [DIR_W-1:0] DIR_STOP_HI = 2'd3;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 100;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	localparam int unsigned CAL_RPM [4][4] = '{
		'{8100, 18900, 22800, 25800},
		'{6900, 16404, 20400, 23700},
		'{7200, 18000, 22500, 23700},
		'{7500, 18000, 24000, 27300}
	};
	localparam int unsigned CAL_PWM [4] = '{64, 128, 192, 255};

	typedef struct {
		logic [MOTOR_W-1:0] motor;
		logic               in1;
		logic               in2;
		logic [PWM_W-1:0]   pwm;
	} drive_t;

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	logic [MOTOR_W-1:0] motor_id;
	logic [DIR_W-1:0]   direction;
	logic [POWER_W-1:0] power;
	logic               res_valid;
	logic               res_stall;
	logic [MOTOR_W-1:0] motor_out;
	logic               bridge_in1;
	logic               bridge_in2;
	logic [PWM_W-1:0]   pwm_duty;

	drive_t exp_drive_q [$];
	int     cmd_cnt;
	int     res_cnt;
	int     mismatch_cnt;
	int     idle_cycles;
	int     tx_idle_pct;
	int     rx_idle_pct;
	int     hold_left;
	bit     hold_start;

	motor_power_to_pwm_calibrated_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.motor_id   (motor_id),
		.direction  (direction),
		.power      (power),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.motor_out  (motor_out),
		.bridge_in1 (bridge_in1),
		.bridge_in2 (bridge_in2),
		.pwm_duty   (pwm_duty)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic drive_t predict_drive(logic [MOTOR_W-1:0] m, logic [DIR_W-1:0] d,
			logic [POWER_W-1:0] p);
		drive_t      r;
		int unsigned pw;
		int unsigned tgt;
		int unsigned dr;
		int unsigned dp;
		bit          hit;
		pw = (p > 7'd100) ? 100 : p;
		tgt = pw * 237;
		r.motor = m;
		r.pwm = 8'd255;
		hit = 1'b0;
		if (tgt < CAL_RPM[m][0]) begin
			r.pwm = PWM_W'(CAL_PWM[0]);
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (!hit && tgt >= CAL_RPM[m][i] && tgt <= CAL_RPM[m][i+1]) begin
					hit = 1'b1;
					dr = CAL_RPM[m][i+1] - CAL_RPM[m][i];
					dp = CAL_PWM[i+1] - CAL_PWM[i];
					if (dr == 0)
						r.pwm = PWM_W'(CAL_PWM[i]);
					else
						r.pwm = PWM_W'(CAL_PWM[i] + ((tgt - CAL_RPM[m][i]) * dp) / dr);
				end
			end
		end
		case (d)
			DIR_FWD: begin
				r.in1 = 1'b1;
				r.in2 = 1'b0;
			end
			DIR_REV: begin
				r.in1 = 1'b0;
				r.in2 = 1'b1;
			end
			default: begin
				r.in1 = 1'b0;
				r.in2 = 1'b0;
				r.pwm = 8'd0;
			end
		endcase
		return r;
	endfunction

	task automatic send_cmd(logic [MOTOR_W-1:0] m, logic [DIR_W-1:0] d, logic [POWER_W-1:0] p);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		motor_id  <= m;
		direction <= d;
		power     <= p;
		do @(posedge clk); while (cmd_stall);
		exp_drive_q.push_back(predict_drive(m, d, p));
		cmd_cnt++;
	endtask

	task automatic send_random(int n);
		repeat (n)
			send_cmd(MOTOR_W'($urandom_range(0, 3)), DIR_W'($urandom_range(0, 3)),
				POWER_W'($urandom_range(0, 127)));
	endtask

	task automatic release_cmd();
		@(negedge clk);
		cmd_valid <= 1'b0;
	endtask

	task automatic wait_results_done();
		while (exp_drive_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		logic [MOTOR_W-1:0] m;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			m = MOTOR_W'(i);
			send_cmd(m, DIR_FWD, 7'd0);
			send_cmd(m, DIR_REV, 7'd100);
			send_cmd(m, DIR_FWD, 7'd127);
			send_cmd(m, DIR_STOP_LO, 7'd50);
			send_cmd(m, DIR_STOP_HI, 7'd101);
			send_cmd(m, DIR_REV, 7'd64);
		end
	endtask

	task automatic test_random_stream();
		send_random(400);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(200);
		tx_idle_pct = 10;
		rx_idle_pct = 10;
		send_random(500);
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		hold_start = 1'b1;
		send_random(40);
		tx_idle_pct = 10;
	endtask

	task automatic test_drain_pause();
		send_random(30);
		release_cmd();
		wait_results_done();
		send_random(30);
	endtask

	// result side: random stall, or a long hold-off on request
	initial begin
		res_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		drive_t e;
		if (arst_n && res_valid && !res_stall) begin
			res_cnt++;
			if (exp_drive_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("%0t: unexpected result motor=%0d in1=%0b in2=%0b pwm=%0d",
						$realtime, motor_out, bridge_in1, bridge_in2, pwm_duty);
			end else begin
				e = exp_drive_q.pop_front();
				if (motor_out !== e.motor || bridge_in1 !== e.in1 ||
						bridge_in2 !== e.in2 || pwm_duty !== e.pwm) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("%0t: mismatch exp motor=%0d in1=%0b in2=%0b pwm=%0d, %s%0d %0b %0b %0d",
							$realtime, e.motor, e.in1, e.in2, e.pwm, "got ",
							motor_out, bridge_in1, bridge_in2, pwm_duty);
				end
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		motor_id = '0;
		direction = '0;
		power = '0;
		cmd_cnt = 0;
		res_cnt = 0;
		mismatch_cnt = 0;
		tx_idle_pct = 10;
		rx_idle_pct = 10;
		hold_start = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_stream();
		test_backpressure();
		test_drain_pause();
		release_cmd();
		wait_results_done();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (exp_drive_q.size() != 0) begin
			$display("%0d results never arrived", exp_drive_q.size());
			mismatch_cnt += exp_drive_q.size();
		end
		$display("Covered %0d commands over all motors, directions and power levels, %0d results",
			cmd_cnt, res_cnt);
		$display("with random idling, a long result hold-off and drain pauses; %0d mismatches",
			mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
